// ----- hw/rtl/bmhq_pkg.sv -----
package bmhq_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int KEY_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_KEY,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/bmhq_ram.sv -----
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hw/rtl/binary_min_heap_queue.sv -----
// Binary min-heap priority queue. Pulse start (while busy is low) with
// i_mode = 0 to insert i_key, or i_mode = 1 to remove the smallest key.
// Exactly one result word follows each command: o_valid is high for one
// cycle with the minimum after the operation (zero when empty), the entry
// count, an empty flag and a status (ok / insert rejected full / delete
// rejected empty). The receiver cannot stall; sample the result ports in
// the o_valid cycle. Keys live in one single-port-write, registered-read
// RAM walked by a small sequencer with its signed key compares, so busy
// stays high for the whole command. Per level, an insert reads the
// parent, compares, and moves the parent down into the hole while the key
// is smaller, then writes the key where it stops. A delete fetches the
// last entry, then per level reads the left child, reads the right child
// and compares, moving the smaller child up while it is below the key,
// until a leaf is reached or the key fits; a delete that empties the queue
// ends after the fetch. The registered RAM read sets the per-level cost;
// rejected commands go straight to the result. A new command is taken in
// the cycle after the result. No clearing pass is needed after reset: only
// data from slots below the count is ever used.
module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic signed [KEY_WIDTH-1:0]   i_key,
    output logic                          o_valid,
    output logic signed [KEY_WIDTH-1:0]   o_min_key,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    output logic                          o_is_empty,
    output logic [1:0]                    o_status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // child index math needs room for 2*idx+2
    localparam int CHD_W = IDX_W + 2;

    // sequencer state
    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [IDX_W-1:0]            r_idx, n_idx;      // current hole
    logic signed [KEY_WIDTH-1:0] r_key, n_key;      // key being sifted
    logic signed [KEY_WIDTH-1:0] r_vl, n_vl;        // left child value
    logic                        r_has_r, n_has_r;  // right child exists
    logic signed [KEY_WIDTH-1:0] r_min, n_min;      // mirror of slot 0
    t_status                     r_status, n_status;

    // RAM port
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [KEY_WIDTH-1:0]        ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [KEY_WIDTH-1:0]        ram_rdata;
    logic signed [KEY_WIDTH-1:0] rd_val;

    // index helpers
    logic [IDX_W-1:0]            parent;
    logic [CHD_W-1:0]            left_c, right_c, cnt_ext;
    logic                        use_r;
    logic signed [KEY_WIDTH-1:0] child_val;
    logic [IDX_W-1:0]            child_idx;

    bmhq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val  = $signed(ram_rdata);
    assign parent  = (r_idx - IDX_W'(1)) >> 1;
    assign left_c  = {1'b0, r_idx, 1'b1};
    assign right_c = left_c + CHD_W'(1);
    assign cnt_ext = CHD_W'(r_cnt);

    // smaller child; left wins a tie
    assign use_r     = r_has_r && (rd_val < r_vl);
    assign child_val = use_r ? rd_val : r_vl;
    assign child_idx = use_r ? right_c[IDX_W-1:0] : left_c[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_status <= STAT_OK;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_status <= n_status;
        end
        r_idx   <= n_idx;
        r_key   <= n_key;
        r_vl    <= n_vl;
        r_has_r <= n_has_r;
        r_min   <= n_min;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_key     = r_key;
        n_vl      = r_vl;
        n_has_r   = r_has_r;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_key;
        ram_raddr = parent;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status = STAT_OK;
                    if (!i_mode) begin
                        if (r_cnt == CNT_W'(DEPTH)) begin
                            n_status = STAT_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = r_cnt[IDX_W-1:0];
                            n_key   = i_key;
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = STAT_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_cnt   = r_cnt - CNT_W'(1);
                            n_state = S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (r_key < rd_val) begin
                    // parent moves down into the hole
                    ram_wdata = ram_rdata;
                    n_idx     = parent;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_LAST: begin
                // last entry sits at the new count
                ram_raddr = r_cnt[IDX_W-1:0];
                n_idx     = '0;
                n_state   = (r_cnt == '0) ? S_DONE : S_DN_KEY;
            end
            S_DN_KEY: begin
                n_key   = rd_val;
                n_state = S_DN_L;
            end
            S_DN_L: begin
                if (left_c >= cnt_ext) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = left_c[IDX_W-1:0];
                    n_state   = S_DN_R;
                end
            end
            S_DN_R: begin
                n_vl      = rd_val;
                n_has_r   = right_c < cnt_ext;
                ram_raddr = right_c[IDX_W-1:0];
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (child_val < r_key) begin
                    ram_wdata = child_val;
                    n_idx     = child_idx;
                    n_state   = S_DN_L;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_min = (ram_we && ram_waddr == '0) ? $signed(ram_wdata) : r_min;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_DONE);
    assign o_min_key  = (r_cnt == '0) ? '0 : r_min;
    assign o_count    = r_cnt;
    assign o_is_empty = (r_cnt == '0);
    assign o_status   = r_status;

endmodule
